>>> design/vn_pkg.sv
// Package for the vector normalize unit: widths, dimension and stage counts.
package vn_pkg;
  localparam int VN_DIM    = 3;
  localparam int COMP_W    = 16;
  localparam int UNIT_FRAC = 14;
  localparam int UNIT_W    = 16;
  localparam int LEN_W     = 16;
  localparam int ABS_W     = COMP_W + 1;
  localparam int SQ_W      = 2 * COMP_W - 1;
  localparam int SUM_W     = SQ_W + $clog2(VN_DIM + 1);
  localparam int QW        = UNIT_FRAC + 1;
  localparam int XW        = 2 * QW;
  localparam int SRW       = QW + 3;
  localparam int DIV_STEPS = 2 * UNIT_FRAC + 1;
  localparam int LW        = (SUM_W + 1) / 2;
  localparam int LPW       = 2 * LW;
  localparam int LRW       = LW + 3;
  localparam int TAIL      = DIV_STEPS + QW;
  localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1 << UNIT_FRAC);
endpackage

>>> design/vector_normalize_unit.sv
// Vector normalize unit: pipelined 3D magnitude and unit vector in fixed point.
//
// Takes one Q4.12 vector per cycle and returns its Q1.14 unit components,
// its Q4.12 magnitude and a zero flag through three front stages
// (absolute value, square, sum), then a 29-stage restoring divider forming
// floor(c^2 * 2^28 / S) per component, one quotient bit per stage, and a
// 15-stage digit-by-digit square root of that quotient. The magnitude root
// is taken in parallel during the divider stages. A stall on the output
// holds the whole pipeline; in_ready is high whenever the last stage is
// empty or its result is being taken.
module vector_normalize_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [vn_pkg::COMP_W-1:0]  in_comp_0,
  input  logic [vn_pkg::COMP_W-1:0]  in_comp_1,
  input  logic [vn_pkg::COMP_W-1:0]  in_comp_2,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [vn_pkg::UNIT_W-1:0]  out_unit_0,
  output logic [vn_pkg::UNIT_W-1:0]  out_unit_1,
  output logic [vn_pkg::UNIT_W-1:0]  out_unit_2,
  output logic [vn_pkg::LEN_W-1:0]   out_length,
  output logic                       out_zero_vector
);
  import vn_pkg::*;

  typedef struct packed {
    logic [VN_DIM-1:0]            neg;
    logic                         zero;
    logic [SUM_W-1:0]             sum;
    logic [VN_DIM-1:0][SUM_W-1:0] drem;
    logic [VN_DIM-1:0][XW-1:0]    x;
    logic [VN_DIM-1:0][SRW-1:0]   srem;
    logic [VN_DIM-1:0][QW-1:0]    root;
    logic [LRW-1:0]               lrem;
    logic [LW-1:0]                lroot;
    logic [LPW-1:0]               lrad;
  } stg_t;

  logic                         en;
  logic [VN_DIM-1:0][COMP_W-1:0] comp;
  logic                         v1_r, v2_r;
  logic [VN_DIM-1:0][ABS_W-1:0] abs1_r;
  logic [VN_DIM-1:0]            neg1_r, neg2_r;
  logic [VN_DIM-1:0][SQ_W-1:0]  sq2_r;
  logic [TAIL:0]                vld_r;
  stg_t                         stg_r   [0:TAIL];
  stg_t                         stg_nxt [0:TAIL];

  assign comp[0] = in_comp_0;
  assign comp[1] = in_comp_1;
  assign comp[2] = in_comp_2;

  assign en       = !vld_r[TAIL] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      vld_r <= '0;
    end else if (en) begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      vld_r <= {vld_r[TAIL-1:0], v2_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < VN_DIM; i++) begin
        neg1_r[i] <= comp[i][COMP_W-1];
        abs1_r[i] <= comp[i][COMP_W-1] ? ABS_W'(-$signed({comp[i][COMP_W-1], comp[i]}))
                                       : ABS_W'(comp[i]);
        sq2_r[i]  <= SQ_W'(abs1_r[i]) * SQ_W'(abs1_r[i]);
      end
      neg2_r <= neg1_r;
    end
  end

  always_comb begin
    logic [SUM_W-1:0] acc;
    acc = '0;
    stg_nxt[0] = '0;
    for (int i = 0; i < VN_DIM; i++) begin
      acc = acc + SUM_W'(sq2_r[i]);
      stg_nxt[0].drem[i] = SUM_W'(sq2_r[i]);
    end
    stg_nxt[0].neg  = neg2_r;
    stg_nxt[0].sum  = acc;
    stg_nxt[0].zero = (acc == '0);
    stg_nxt[0].lrad = LPW'(acc);
  end

  for (genvar k = 1; k <= TAIL; k++) begin : g_stage
    always_comb begin
      logic [SUM_W-1:0] dt;
      logic [SRW-1:0]   sr, st;
      logic [LRW-1:0]   lr, lt;
      stg_nxt[k] = stg_r[k-1];
      if (k <= DIV_STEPS) begin
        for (int i = 0; i < VN_DIM; i++) begin
          dt = stg_r[k-1].drem[i];
          if (dt >= stg_r[k-1].sum) begin
            dt = dt - stg_r[k-1].sum;
            stg_nxt[k].x[i] = {stg_r[k-1].x[i][XW-2:0], 1'b1};
          end else begin
            stg_nxt[k].x[i] = {stg_r[k-1].x[i][XW-2:0], 1'b0};
          end
          stg_nxt[k].drem[i] = {dt[SUM_W-2:0], 1'b0};
        end
      end else begin
        for (int i = 0; i < VN_DIM; i++) begin
          sr = {stg_r[k-1].srem[i][SRW-3:0], stg_r[k-1].x[i][XW-1 -: 2]};
          st = SRW'({stg_r[k-1].root[i], 2'b01});
          if (sr >= st) begin
            stg_nxt[k].srem[i] = sr - st;
            stg_nxt[k].root[i] = {stg_r[k-1].root[i][QW-2:0], 1'b1};
          end else begin
            stg_nxt[k].srem[i] = sr;
            stg_nxt[k].root[i] = {stg_r[k-1].root[i][QW-2:0], 1'b0};
          end
          stg_nxt[k].x[i] = {stg_r[k-1].x[i][XW-3:0], 2'b00};
        end
      end
      if (k <= LW) begin
        lr = {stg_r[k-1].lrem[LRW-3:0], stg_r[k-1].lrad[LPW-1 -: 2]};
        lt = LRW'({stg_r[k-1].lroot, 2'b01});
        if (lr >= lt) begin
          stg_nxt[k].lrem  = lr - lt;
          stg_nxt[k].lroot = {stg_r[k-1].lroot[LW-2:0], 1'b1};
        end else begin
          stg_nxt[k].lrem  = lr;
          stg_nxt[k].lroot = {stg_r[k-1].lroot[LW-2:0], 1'b0};
        end
        stg_nxt[k].lrad = {stg_r[k-1].lrad[LPW-3:0], 2'b00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= TAIL; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  logic [VN_DIM-1:0][UNIT_W-1:0] unit;

  always_comb begin
    logic [UNIT_W-1:0] u;
    for (int i = 0; i < VN_DIM; i++) begin
      u = UNIT_W'(stg_r[TAIL].root[i]);
      if (stg_r[TAIL].zero) begin
        unit[i] = '0;
      end else if (stg_r[TAIL].neg[i]) begin
        unit[i] = UNIT_W'(-u);
      end else begin
        unit[i] = u;
      end
    end
  end

  assign out_valid       = vld_r[TAIL];
  assign out_unit_0      = unit[0];
  assign out_unit_1      = unit[1];
  assign out_unit_2      = unit[2];
  assign out_length      = stg_r[TAIL].lroot[LEN_W-1:0];
  assign out_zero_vector = stg_r[TAIL].zero;
endmodule

>>> design/vn_checker.sv
// Port-level checker for the vector normalize unit, bound to the top level.
module vn_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [vn_pkg::UNIT_W-1:0]  out_unit_0,
  input logic [vn_pkg::UNIT_W-1:0]  out_unit_1,
  input logic [vn_pkg::UNIT_W-1:0]  out_unit_2,
  input logic [vn_pkg::LEN_W-1:0]   out_length,
  input logic                       out_zero_vector
);
  import vn_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_unit_0) && $stable(out_unit_1)
      && $stable(out_unit_2) && $stable(out_length) && $stable(out_zero_vector))
    else $error("result changed while stalled");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_vector |-> out_unit_0 == '0 && out_unit_1 == '0
      && out_unit_2 == '0 && out_length == '0)
    else $error("zero vector with nonzero result");

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_zero_vector |-> out_length != '0)
    else $error("nonzero vector with zero length");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_unit_0) <= $signed(UNIT_ONE)
      && $signed(out_unit_0) >= -$signed(UNIT_ONE)
      && $signed(out_unit_1) <= $signed(UNIT_ONE)
      && $signed(out_unit_1) >= -$signed(UNIT_ONE)
      && $signed(out_unit_2) <= $signed(UNIT_ONE)
      && $signed(out_unit_2) >= -$signed(UNIT_ONE))
    else $error("unit component exceeds one");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
endmodule

bind vector_normalize_unit vn_checker u_vn_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_unit_0      (out_unit_0),
  .out_unit_1      (out_unit_1),
  .out_unit_2      (out_unit_2),
  .out_length      (out_length),
  .out_zero_vector (out_zero_vector)
);

>>> verif/vector_normalize_unit_tb.sv
// Testbench for vector_normalize_unit: directed table plus random vectors, scoreboard check.
module vector_normalize_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vn_pkg::*;

  typedef struct {
    logic [UNIT_W-1:0] unit_v [VN_DIM];
    logic [LEN_W-1:0]  len;
    logic              zero;
  } norm_t;

  typedef struct {
    logic [COMP_W-1:0] comp [VN_DIM];
    bit                typed;
    norm_t             res;
  } dir_row_t;

  localparam int NUM_RANDOM = 1150;
  localparam int WATCHDOG   = 3000;
  localparam int HOLD_OFF   = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COMP_W-1:0] in_comp_0 = '0;
  logic [COMP_W-1:0] in_comp_1 = '0;
  logic [COMP_W-1:0] in_comp_2 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [UNIT_W-1:0] out_unit_0;
  logic [UNIT_W-1:0] out_unit_1;
  logic [UNIT_W-1:0] out_unit_2;
  logic [LEN_W-1:0]  out_length;
  logic              out_zero_vector;

  norm_t pending_norms [$];
  norm_t drive_norm;
  int    mismatches = 0;
  int    results_seen = 0;
  int    items_sent = 0;
  int    zeros_seen = 0;
  int    idle_cycles = 0;
  bit    hold_req = 1'b0;
  bit    hold_done = 1'b0;
  bit    no_idle = 1'b0;

  vector_normalize_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_comp_0       (in_comp_0),
    .in_comp_1       (in_comp_1),
    .in_comp_2       (in_comp_2),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_unit_0      (out_unit_0),
    .out_unit_1      (out_unit_1),
    .out_unit_2      (out_unit_2),
    .out_length      (out_length),
    .out_zero_vector (out_zero_vector)
  );

  always #6 clk = ~clk;

  // largest q <= 1.0 with q^2 * sum <= sq * 2^28
  function automatic logic [UNIT_W-1:0] unit_mag(longint unsigned sq, longint unsigned sum);
    longint unsigned target;
    longint unsigned q;
    longint unsigned t;
    target = sq << (2 * UNIT_FRAC);
    q = 0;
    for (int b = UNIT_FRAC; b >= 0; b--) begin
      t = q | (64'd1 << b);
      if (t <= (64'd1 << UNIT_FRAC) && t * t * sum <= target) q = t;
    end
    return UNIT_W'(q);
  endfunction

  function automatic norm_t normalize_vec(logic [COMP_W-1:0] comp [VN_DIM]);
    norm_t r;
    longint unsigned sq [VN_DIM];
    longint unsigned sum;
    longint unsigned root;
    longint unsigned t;
    longint signed   c;
    sum = 0;
    for (int i = 0; i < VN_DIM; i++) begin
      c = longint'($signed(comp[i]));
      if (c < 0) c = -c;
      sq[i] = longint'(c) * longint'(c);
      sum += sq[i];
    end
    r.zero = (sum == 0);
    root = 0;
    for (int b = LEN_W - 1; b >= 0; b--) begin
      t = root | (64'd1 << b);
      if (t * t <= sum) root = t;
    end
    r.len = LEN_W'(root);
    for (int i = 0; i < VN_DIM; i++) begin
      r.unit_v[i] = '0;
      if (sum != 0) begin
        r.unit_v[i] = unit_mag(sq[i], sum);
        if (comp[i][COMP_W-1]) r.unit_v[i] = -r.unit_v[i];
      end
    end
    return r;
  endfunction

  function automatic dir_row_t axis_row(int axis, logic [COMP_W-1:0] v);
    dir_row_t d;
    for (int i = 0; i < VN_DIM; i++) begin
      d.comp[i] = '0;
      d.res.unit_v[i] = '0;
    end
    d.comp[axis] = v;
    d.typed = 1'b1;
    d.res.unit_v[axis] = v[COMP_W-1] ? -UNIT_ONE : UNIT_ONE;
    d.res.len = v[COMP_W-1] ? -v : v;
    d.res.zero = (v == 0);
    if (v == 0) d.res.unit_v[axis] = '0;
    return d;
  endfunction

  function automatic dir_row_t free_row(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b,
                                        logic [COMP_W-1:0] c);
    dir_row_t d;
    d.comp[0] = a;
    d.comp[1] = b;
    d.comp[2] = c;
    d.typed = 1'b0;
    return d;
  endfunction

  function automatic logic [COMP_W-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'h8000;
      2: return 16'h7fff;
      3: return COMP_W'($signed($urandom_range(0, 16)) - 8);
      4: return COMP_W'($signed($urandom_range(0, 1024)) - 512);
      default: return COMP_W'($urandom);
    endcase
  endfunction

  task automatic send_vec(logic [COMP_W-1:0] comp [VN_DIM], norm_t res);
    int gap;
    @(negedge clk);
    in_comp_0  <= comp[0];
    in_comp_1  <= comp[1];
    in_comp_2  <= comp[2];
    drive_norm <= res;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    gap = 0;
    if (!no_idle) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: gap = $urandom_range(1, 3);
        4:          gap = $urandom_range(10, 40);
        default:    gap = 0;
      endcase
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // receiver: random back pressure, one long hold-off on request
  initial begin
    int gap_left;
    gap_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
        hold_done = 1'b1;
      end else if (gap_left > 0 && !no_idle) begin
        out_ready <= 1'b0;
        gap_left--;
      end else begin
        out_ready <= 1'b1;
        case ($urandom_range(0, 19))
          0, 1, 2, 3: gap_left = $urandom_range(1, 3);
          4:          gap_left = $urandom_range(10, 40);
          default:    gap_left = 0;
        endcase
      end
    end
  end

  // scoreboard and watchdog
  always @(posedge clk) begin
    norm_t got;
    norm_t want;
    if (rst_n) begin
      if (in_valid && in_ready) pending_norms.push_back(drive_norm);
      if (out_valid && out_ready) begin
        results_seen++;
        got.unit_v[0] = out_unit_0;
        got.unit_v[1] = out_unit_1;
        got.unit_v[2] = out_unit_2;
        got.len = out_length;
        got.zero = out_zero_vector;
        if (got.zero) zeros_seen++;
        if (pending_norms.size() == 0) begin
          $error("result transfer with nothing pending");
          mismatches++;
        end else begin
          want = pending_norms.pop_front();
          for (int i = 0; i < VN_DIM; i++)
            if (got.unit_v[i] !== want.unit_v[i]) begin
              $error("unit_%0d: expected %0d, got %0d", i,
                     $signed(want.unit_v[i]), $signed(got.unit_v[i]));
              mismatches++;
            end
          if (got.len !== want.len) begin
            $error("length: expected %0d, got %0d", want.len, got.len);
            mismatches++;
          end
          if (got.zero !== want.zero) begin
            $error("zero_vector: expected %0b, got %0b", want.zero, got.zero);
            mismatches++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (!in_valid && pending_norms.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t dir_rows [$];
    logic [COMP_W-1:0] comp [VN_DIM];
    norm_t exp_res;
    dir_rows.push_back(axis_row(0, '0));
    dir_rows.push_back(axis_row(0, 16'h1000));
    dir_rows.push_back(axis_row(0, 16'h8000));
    dir_rows.push_back(axis_row(1, 16'h7fff));
    dir_rows.push_back(axis_row(1, 16'hffff));
    dir_rows.push_back(axis_row(2, 16'h0001));
    dir_rows.push_back(axis_row(2, 16'h8000));
    dir_rows.push_back(free_row(16'h8000, 16'h8000, 16'h8000));
    dir_rows.push_back(free_row(16'h7fff, 16'h7fff, 16'h7fff));
    dir_rows.push_back(free_row(16'h7fff, 16'h8000, 16'h0001));
    dir_rows.push_back(free_row(16'h1000, 16'h1000, 16'h0000));
    dir_rows.push_back(free_row(16'h0003, 16'hfffc, 16'h0000));
    dir_rows.push_back(free_row(16'h0001, 16'h0001, 16'h0001));
    dir_rows.push_back(free_row(16'hffff, 16'h7fff, 16'hffff));
    dir_rows.push_back(free_row(16'h5555, 16'haaaa, 16'h3c3c));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    no_idle = 1'b1;
    foreach (dir_rows[k]) begin
      if (dir_rows[k].typed)
        exp_res = dir_rows[k].res;
      else
        exp_res = normalize_vec(dir_rows[k].comp);
      send_vec(dir_rows[k].comp, exp_res);
      if (k == 7) no_idle = 1'b0;
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 300) hold_req = 1'b1;
      no_idle = (n >= 700 && n < 800);
      case ($urandom_range(0, 9))
        0: begin
          foreach (comp[i]) comp[i] = '0;
          comp[$urandom_range(0, VN_DIM - 1)] = rand_comp();
        end
        1: foreach (comp[i]) comp[i] = '0;
        default: foreach (comp[i]) comp[i] = rand_comp();
      endcase
      send_vec(comp, normalize_vec(comp));
    end
    @(negedge clk);
    in_valid <= 1'b0;
    no_idle = 1'b0;

    while (pending_norms.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("sent %0d vectors, checked %0d results (%0d zero vectors), long hold-off %s",
             items_sent, results_seen, zeros_seen, hold_done ? "done" : "missed");
    if (mismatches == 0 && pending_norms.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_norms.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

>>> vector_normalize_unit.f
design/vn_pkg.sv
design/vector_normalize_unit.sv
design/vn_checker.sv
verif/vector_normalize_unit_tb.sv
